FILE: rtl/pcm16_pkg.sv
// Package for the PCM sample to int16 converter.
// Format codes, float field constants and a stage payload type. No dependencies.
package pcm16_pkg;

    localparam logic [2:0] FMT_FLOAT32 = 3'd0;
    localparam logic [2:0] FMT_INT16   = 3'd1;
    localparam logic [2:0] FMT_INT24   = 3'd2;
    localparam logic [2:0] FMT_INT32   = 3'd3;

    localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0]  EXP_ONE      = 8'd127;
    localparam logic [14:0] SCALE        = 15'd32767;

    // Float and integer path fields carried from stage 1 to stage 2
    typedef struct packed {
        logic        sign;
        logic        zero_out;   // NaN, silent, unsupported format, or tiny value
        logic        clamp;      // magnitude at or above one
        logic        int_path;   // result is the integer word below
        logic [15:0] int_word;
        logic [7:0]  expo;
        logic [23:0] mant;       // with hidden bit
    } stage1_t;

endpackage

FILE: rtl/pcm_sample_to_int16_converter_unit.sv
// Top level of the PCM sample to int16 converter.
// Depends on pcm16_pkg for format codes and the stage payload type.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready/cfg_data) sets source_format; write it
//    only while no transaction is in flight. cfg_ready is always high.
//  - Input channel (in_valid/in_ready, sample_bits, silent) takes one sample
//    transaction per cycle while in_ready is high.
//  - Output channel (out_valid/out_ready, pcm_out) returns one result per input,
//    in order.
//  - From input acceptance to out_valid a sample passes decode and classify,
//    multiply the mantissa by 32767, then shift and truncate toward zero.
//  - Throughput is one sample per cycle while the pipeline is not held; it advances as a whole.
//  - When out_ready is low with the last stage full, every stage holds and
//    in_ready drops, so nothing is lost or repeated.
//  - Reset clears the valid bits and sets source_format to float32.
module pcm_sample_to_int16_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample_bits,
    input  logic        silent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] pcm_out
);

    logic [2:0] fmt_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic adv;
    pcm16_pkg::stage1_t s1_next, s1_reg;

    // stage 2 and stage 3 registers
    logic        s2_sign_reg, s2_zero_reg, s2_clamp_reg, s2_int_reg;
    logic [15:0] s2_word_reg;
    logic [7:0]  s2_expo_reg;
    logic [38:0] s2_prod_reg;
    logic [15:0] s3_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !v3_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v3_reg;
    assign pcm_out   = s3_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= pcm16_pkg::FMT_FLOAT32;
        else if (cfg_valid)
            fmt_reg <= cfg_data;
    end

    // stage 1: format decode and float classification
    always_comb
    begin
        s1_next          = '0;
        s1_next.sign     = sample_bits[31];
        s1_next.expo     = sample_bits[30:23];
        s1_next.mant     = {1'b1, sample_bits[22:0]};
        unique case (fmt_reg)
            pcm16_pkg::FMT_FLOAT32:
            begin
                if (sample_bits[30:23] == pcm16_pkg::EXP_ALL_ONES
                    && sample_bits[22:0] != 23'd0)
                    s1_next.zero_out = 1'b1;
                else if (sample_bits[30:23] >= pcm16_pkg::EXP_ONE)
                    s1_next.clamp = 1'b1;
                else if (sample_bits[30:23] < 8'd112)
                    s1_next.zero_out = 1'b1;  // below 2^-15, scaled under one
            end
            pcm16_pkg::FMT_INT16:
            begin
                s1_next.int_path = 1'b1;
                s1_next.int_word = sample_bits[15:0];
            end
            pcm16_pkg::FMT_INT24:
            begin
                s1_next.int_path = 1'b1;
                s1_next.int_word = sample_bits[23:8];
            end
            pcm16_pkg::FMT_INT32:
            begin
                s1_next.int_path = 1'b1;
                s1_next.int_word = sample_bits[31:16];
            end
            default: s1_next.zero_out = 1'b1;
        endcase
        if (silent)
            s1_next.zero_out = 1'b1;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1 and stage 2 registers: mantissa times 32767 in stage 2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= s1_next;
            s2_sign_reg  <= s1_reg.sign;
            s2_zero_reg  <= s1_reg.zero_out;
            s2_clamp_reg <= s1_reg.clamp;
            s2_int_reg   <= s1_reg.int_path;
            s2_word_reg  <= s1_reg.int_word;
            s2_expo_reg  <= s1_reg.expo;
            s2_prod_reg  <= 39'(s1_reg.mant) * 39'(pcm16_pkg::SCALE);
        end
    end

    // stage 3: single-precision rounding, truncation toward zero, sign, clamp and result select
    logic [38:0] shifted;
    logic [38:0] rnd;
    logic [4:0]  msb;
    logic [5:0]  lsb;
    logic [38:0] lsb_mask, half, low_bits;
    logic [39:0] rounded;
    logic [5:0]  sh;
    logic [14:0] mag;
    logic [15:0] res;

    always_comb
    begin
        // product = m * 32767 * 2^(e-150); m*32767 in [2^38 - 2^23, 2^39)
        // normalize: msb at 38 or 37; keep 24 bits
        lsb      = s2_prod_reg[38] ? 6'd15 : 6'd14;
        lsb_mask = (39'd1 << lsb);
        half     = lsb_mask >> 1;
        low_bits = s2_prod_reg & (lsb_mask - 39'd1);
        rnd      = s2_prod_reg & ~(lsb_mask - 39'd1);
        rounded  = {1'b0, rnd};
        if (low_bits > half || (low_bits == half && (s2_prod_reg & lsb_mask) != 39'd0))
            rounded = {1'b0, rnd} + {1'b0, lsb_mask};
        // value = rounded * 2^(e-150); integer part = rounded >> (150-e)
        sh       = 6'(8'd150 - s2_expo_reg);
        shifted  = 39'(rounded >> sh);
        msb      = 5'd0;
        mag      = shifted[14:0];
        if (s2_clamp_reg)
            mag = pcm16_pkg::SCALE;
        res = s2_sign_reg ? 16'(-{1'b0, mag}) : {1'b0, mag};
        if (s2_int_reg)
            res = s2_word_reg;
        if (s2_zero_reg)
            res = 16'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s3_reg <= res + 16'(msb);
    end

endmodule
